/* rtl/gbsp_pkg.sv */
// Shared types, codes and helpers of the GIF block structure parser.
// No dependencies; imported by every module of the parser.
package gbsp_pkg;

    typedef enum logic [3:0] {
        PH_SIG     = 4'd0,
        PH_SCREEN  = 4'd1,
        PH_GTAB    = 4'd2,
        PH_TAG     = 4'd3,
        PH_EXTLAB  = 4'd4,
        PH_SKIPLEN = 4'd5,
        PH_SKIPDAT = 4'd6,
        PH_COMLEN  = 4'd7,
        PH_COMDAT  = 4'd8,
        PH_GCELEN  = 4'd9,
        PH_GCEDAT  = 4'd10,
        PH_IMG     = 4'd11,
        PH_LTAB    = 4'd12,
        PH_LZW     = 4'd13,
        PH_UNK     = 4'd14
    } t_phase;

    typedef enum logic [3:0] {
        KIND_HEADER      = 4'd0,
        KIND_PLAIN_TEXT  = 4'd1,
        KIND_GFX_CONTROL = 4'd2,
        KIND_COMMENT     = 4'd3,
        KIND_COMMENT_END = 4'd4,
        KIND_APPLICATION = 4'd5,
        KIND_IMAGE       = 4'd6,
        KIND_TRAILER     = 4'd7,
        KIND_NOT_GIF     = 4'd8,
        KIND_UNKNOWN_TAG = 4'd9,
        KIND_TAG_2E      = 4'd10
    } t_kind;

    localparam logic [7:0] TAG_EXTENSION = 8'h21;
    localparam logic [7:0] TAG_IMAGE     = 8'h2c;
    localparam logic [7:0] TAG_TRAILER   = 8'h3b;
    localparam logic [7:0] TAG_2E        = 8'h2e;
    localparam logic [7:0] LBL_PLAIN     = 8'h01;
    localparam logic [7:0] LBL_GFX       = 8'hf9;
    localparam logic [7:0] LBL_COMMENT   = 8'hfe;
    localparam logic [7:0] LBL_APP       = 8'hff;

    localparam int unsigned SKIP_W = 10;

    typedef struct packed {
        t_phase             phase;
        logic [3:0]         fc;
        logic [SKIP_W-1:0]  skip;
        logic [3:0][15:0]   words;
        logic [7:0]         flags;
        logic [7:0]         index;
        logic               halted;
    } t_parse_state;

    // All-zero state; PH_SIG is code zero.
    localparam t_parse_state PARSE_RESET = t_parse_state'('0);

    typedef struct packed {
        t_kind       kind;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [15:0] word_d;
        logic [7:0]  flag_byte;
        logic [3:0]  color_bits;
        logic [7:0]  color_index;
        logic        has_transparency;
        logic        local_table;
        logic        interlaced;
        logic [7:0]  text_byte;
    } t_record;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h47;
            2'd1:    c = 8'h49;
            2'd2:    c = 8'h46;
            default: c = 8'h38;
        endcase
        return c;
    endfunction

    // Color table size in bytes: 3 << (size field + 1), at most 768.
    function automatic logic [SKIP_W-1:0] table_bytes(input logic [7:0] f);
        return SKIP_W'(SKIP_W'(3) << ({1'b0, f[2:0]} + 4'd1));
    endfunction

endpackage

/* rtl/gbsp_step.sv */
// Next-state and record logic of the parser for one byte.
// Depends on gbsp_pkg.
module gbsp_step
    import gbsp_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_data_byte,
    input  logic         i_first_byte,
    output t_parse_state o_state,
    output logic         o_rec_valid,
    output t_record      o_record
);

    t_parse_state       s;
    t_parse_state       n;
    t_record            r;
    logic               v;
    logic [7:0]         b;
    logic [1:0]         w;
    logic [15:0]        word_new;
    logic [SKIP_W-1:0]  skip_dec;
    logic [3:0]         cbits;

    assign b        = i_data_byte;
    assign cbits    = {1'b0, b[2:0]} + 4'd1;

    always_comb begin
        s = i_first_byte ? PARSE_RESET : i_state;
        n = s;
        r = '0;
        v = 1'b0;
        w = s.fc[2:1];
        word_new = s.fc[0] ? {b, s.words[w][7:0]} : {8'h00, b};
        skip_dec = (s.skip != '0) ? s.skip - SKIP_W'(1) : '0;

        if (!s.halted) begin
            unique case (s.phase)
                PH_SIG: begin
                    if (s.fc < 4'd4) begin
                        n.fc = s.fc + 4'd1;
                        if (b != sig_byte(s.fc[1:0])) begin
                            n.halted = 1'b1;
                            v = 1'b1;
                            r.kind = KIND_NOT_GIF;
                        end
                    end else if (s.fc == 4'd4) begin
                        n.words[2] = {8'h00, b};
                        n.fc = 4'd5;
                    end else begin
                        n.words[2] = {b, s.words[2][7:0]};
                        n.phase = PH_SCREEN;
                        n.fc = 4'd0;
                    end
                end
                PH_SCREEN: begin
                    if (s.fc < 4'd4) begin
                        n.words[w] = word_new;
                        n.fc = s.fc + 4'd1;
                    end else if (s.fc == 4'd4) begin
                        n.flags = b;
                        n.fc = 4'd5;
                        v = 1'b1;
                        r.kind = KIND_HEADER;
                        r.word_a = s.words[0];
                        r.word_b = s.words[1];
                        r.word_c = s.words[2];
                        r.flag_byte = b;
                        r.color_bits = cbits;
                    end else if (s.fc == 4'd5) begin
                        n.fc = 4'd6;
                    end else begin
                        n.fc = 4'd0;
                        if (s.flags[7]) begin
                            n.skip = table_bytes(s.flags);
                            n.phase = PH_GTAB;
                        end else begin
                            n.phase = PH_TAG;
                        end
                    end
                end
                PH_GTAB, PH_LTAB: begin
                    n.skip = skip_dec;
                    if (skip_dec == '0) begin
                        n.phase = (s.phase == PH_GTAB) ? PH_TAG : PH_LZW;
                    end
                end
                PH_TAG: begin
                    if (b == TAG_EXTENSION) begin
                        n.phase = PH_EXTLAB;
                    end else if (b == TAG_IMAGE) begin
                        n.phase = PH_IMG;
                        n.fc = 4'd0;
                    end else if (b == TAG_TRAILER) begin
                        n.halted = 1'b1;
                        v = 1'b1;
                        r.kind = KIND_TRAILER;
                    end else if (b == TAG_2E) begin
                        n.halted = 1'b1;
                        v = 1'b1;
                        r.kind = KIND_TAG_2E;
                    end else begin
                        n.words[0] = {8'h00, b};
                        n.phase = PH_UNK;
                    end
                end
                PH_UNK: begin
                    n.halted = 1'b1;
                    v = 1'b1;
                    r.kind = KIND_UNKNOWN_TAG;
                    r.word_a = {8'h00, s.words[0][7:0]};
                    r.word_b = {8'h00, b};
                end
                PH_EXTLAB: begin
                    if (b == LBL_PLAIN) begin
                        n.phase = PH_SKIPLEN;
                        v = 1'b1;
                        r.kind = KIND_PLAIN_TEXT;
                    end else if (b == LBL_APP) begin
                        n.phase = PH_SKIPLEN;
                        v = 1'b1;
                        r.kind = KIND_APPLICATION;
                    end else if (b == LBL_COMMENT) begin
                        n.phase = PH_COMLEN;
                    end else if (b == LBL_GFX) begin
                        n.phase = PH_GCELEN;
                        n.fc = 4'd0;
                        n.flags = 8'h00;
                        n.index = 8'h00;
                        n.words[0] = 16'h0000;
                    end else begin
                        n.phase = PH_SKIPLEN;
                    end
                end
                PH_SKIPLEN, PH_COMLEN, PH_GCELEN: begin
                    if (b == 8'h00) begin
                        n.phase = PH_TAG;
                        if (s.phase == PH_COMLEN) begin
                            v = 1'b1;
                            r.kind = KIND_COMMENT_END;
                        end else if (s.phase == PH_GCELEN) begin
                            v = 1'b1;
                            r.kind = KIND_GFX_CONTROL;
                            r.word_a = s.words[0];
                            r.flag_byte = s.flags;
                            r.color_index = s.index;
                            r.has_transparency = s.flags[0];
                        end
                    end else begin
                        n.skip = SKIP_W'(b);
                        if (s.phase == PH_GCELEN) begin
                            n.fc = (s.fc == 4'd0) ? 4'd1 : 4'd15;
                            n.phase = PH_GCEDAT;
                        end else if (s.phase == PH_COMLEN) begin
                            n.phase = PH_COMDAT;
                        end else begin
                            n.phase = PH_SKIPDAT;
                        end
                    end
                end
                PH_SKIPDAT, PH_COMDAT, PH_GCEDAT: begin
                    n.skip = skip_dec;
                    if (skip_dec == '0) begin
                        if (s.phase == PH_SKIPDAT) begin
                            n.phase = PH_SKIPLEN;
                        end else if (s.phase == PH_COMDAT) begin
                            n.phase = PH_COMLEN;
                        end else begin
                            n.phase = PH_GCELEN;
                        end
                    end
                    if (s.phase == PH_COMDAT) begin
                        v = 1'b1;
                        r.kind = KIND_COMMENT;
                        r.text_byte = b;
                    end
                    // Capture flags, delay and index from the first sub-block.
                    if (s.phase == PH_GCEDAT && s.fc >= 4'd1 && s.fc <= 4'd4) begin
                        case (s.fc)
                            4'd1:    n.flags = b;
                            4'd2:    n.words[0] = {8'h00, b};
                            4'd3:    n.words[0] = {b, s.words[0][7:0]};
                            default: n.index = b;
                        endcase
                        n.fc = s.fc + 4'd1;
                    end
                end
                PH_IMG: begin
                    if (s.fc < 4'd8) begin
                        n.words[w] = word_new;
                        n.fc = s.fc + 4'd1;
                    end else begin
                        n.flags = b;
                        n.fc = 4'd0;
                        if (b[7]) begin
                            n.skip = table_bytes(b);
                            n.phase = PH_LTAB;
                        end else begin
                            n.phase = PH_LZW;
                        end
                        v = 1'b1;
                        r.kind = KIND_IMAGE;
                        r.word_a = s.words[0];
                        r.word_b = s.words[1];
                        r.word_c = s.words[2];
                        r.word_d = s.words[3];
                        r.flag_byte = b;
                        r.color_bits = cbits;
                        r.local_table = b[7];
                        r.interlaced = b[6];
                    end
                end
                PH_LZW: begin
                    // Drop the LZW code size byte; data follows as sub-blocks.
                    n.phase = PH_SKIPLEN;
                end
                default: begin
                    n.phase = PH_TAG;
                end
            endcase
        end
    end

    assign o_state     = n;
    assign o_rec_valid = v;
    assign o_record    = r;

endmodule

/* rtl/gbsp_out_reg.sv */
// Result register of the parser: holds one record beat until taken.
// Depends on gbsp_pkg.
module gbsp_out_reg
    import gbsp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  logic    i_rec_valid,
    input  t_record i_record,
    input  logic    i_stall,
    output logic    o_busy,
    output logic    o_valid,
    output t_record o_record
);

    logic    r_valid;
    t_record r_record;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_rec_valid;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_rec_valid) begin
            r_record <= i_record;
        end
    end

    // Full and not taken this cycle: hold off the next byte.
    assign o_busy   = r_valid && i_stall;
    assign o_valid  = r_valid;
    assign o_record = r_record;

endmodule

/* rtl/gif_block_structure_parser.sv */
// GIF block structure parser, one file byte per beat.
// A record is registered and appears on the output in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the output register is the only buffer, so a
// record waiting under an output stall holds the input until it is taken.
// Reset (synchronous, active low) clears the parse state and empties the output;
// a byte with first_byte set restarts parsing at the signature.
module gif_block_structure_parser
    import gbsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_record_kind,
    output logic [15:0] o_word_a,
    output logic [15:0] o_word_b,
    output logic [15:0] o_word_c,
    output logic [15:0] o_word_d,
    output logic [7:0]  o_flag_byte,
    output logic [3:0]  o_color_bits,
    output logic [7:0]  o_color_index,
    output logic        o_has_transparency,
    output logic        o_local_table,
    output logic        o_interlaced,
    output logic [7:0]  o_text_byte
);

    t_parse_state r_state;
    t_parse_state n_state;
    logic         rec_valid;
    t_record      rec;
    t_record      out_rec;
    logic         accept;
    logic         busy;

    assign accept     = i_in_valid && !busy;
    assign o_in_stall = busy;

    gbsp_step u_step (
        .i_state      (r_state),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .o_state      (n_state),
        .o_rec_valid  (rec_valid),
        .o_record     (rec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_RESET;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    gbsp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_rec_valid (rec_valid),
        .i_record    (rec),
        .i_stall     (i_out_stall),
        .o_busy      (busy),
        .o_valid     (o_out_valid),
        .o_record    (out_rec)
    );

    assign o_record_kind      = out_rec.kind;
    assign o_word_a           = out_rec.word_a;
    assign o_word_b           = out_rec.word_b;
    assign o_word_c           = out_rec.word_c;
    assign o_word_d           = out_rec.word_d;
    assign o_flag_byte        = out_rec.flag_byte;
    assign o_color_bits       = out_rec.color_bits;
    assign o_color_index      = out_rec.color_index;
    assign o_has_transparency = out_rec.has_transparency;
    assign o_local_table      = out_rec.local_table;
    assign o_interlaced       = out_rec.interlaced;
    assign o_text_byte        = out_rec.text_byte;

endmodule

/* rtl/gbsp_checker.sv */
// Port-level checks of the GIF block structure parser, bound to the top level.
// Depends on gbsp_pkg and gif_block_structure_parser.
module gbsp_checker
    import gbsp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_record_kind,
    input logic [3:0]  o_color_bits
);

    // A stalled record stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output record dropped under stall");

    // A stalled record keeps its kind.
    a_kind_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_record_kind))
        else $error("record kind changed under stall");

    // Input is held off only by a full, stalled output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting record");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("record offered right after reset");

    // Header and image records carry a table size of one to eight bits.
    a_color_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_record_kind == KIND_HEADER || o_record_kind == KIND_IMAGE)
        |-> o_color_bits >= 4'd1 && o_color_bits <= 4'd8)
        else $error("color bits out of range");

endmodule

bind gif_block_structure_parser gbsp_checker u_gbsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_record_kind (o_record_kind),
    .o_color_bits  (o_color_bits)
);

/* tb/gif_record_checker.sv */
// Checker for the GIF block structure parser: watches both channels, walks each
// accepted byte through its own parser model and compares every record it predicts.
// Depends on gbsp_pkg for the phase, kind and record types and the tag codes.
module gif_record_checker
    import gbsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_record_kind,
    input  logic [15:0] i_word_a,
    input  logic [15:0] i_word_b,
    input  logic [15:0] i_word_c,
    input  logic [15:0] i_word_d,
    input  logic [7:0]  i_flag_byte,
    input  logic [3:0]  i_color_bits,
    input  logic [7:0]  i_color_index,
    input  logic        i_has_transparency,
    input  logic        i_local_table,
    input  logic        i_interlaced,
    input  logic [7:0]  i_text_byte,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_records,
    output logic [15:0] o_kinds_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] GIF_MAGIC = 32'h3846_4947;

    // parser model state
    t_phase      ph;
    logic [3:0]  fcnt;
    logic [9:0]  skip_left;
    logic [15:0] wd [4];
    logic [7:0]  sv_flags;
    logic [7:0]  sv_index;
    logic        stopped;

    t_record     pending_records [$];
    int          errors = 0;
    int          records_seen = 0;
    logic [15:0] kinds = '0;

    function automatic logic [9:0] color_table_len(input logic [7:0] f);
        return 10'd3 << ({1'b0, f[2:0]} + 4'd1);
    endfunction

    task automatic reset_walker();
        ph = PH_SIG;
        fcnt = '0;
        skip_left = '0;
        for (int i = 0; i < 4; i++) wd[i] = '0;
        sv_flags = '0;
        sv_index = '0;
        stopped = 1'b0;
    endtask

    task automatic walk_gif_byte(input logic [7:0] b, input logic restart,
                                 output logic got, output t_record rec);
        t_phase was;
        got = 1'b0;
        rec = '0;
        if (restart) reset_walker();
        if (!stopped) begin
            case (ph)
                PH_SIG: begin
                    if (fcnt < 4'd4) begin
                        if (b != GIF_MAGIC[fcnt[1:0]*8 +: 8]) begin
                            stopped = 1'b1;
                            got = 1'b1;
                            rec.kind = KIND_NOT_GIF;
                        end else begin
                            fcnt = fcnt + 4'd1;
                        end
                    end else if (fcnt == 4'd4) begin
                        wd[2] = {8'h00, b};
                        fcnt = 4'd5;
                    end else begin
                        wd[2][15:8] = b;
                        ph = PH_SCREEN;
                        fcnt = '0;
                    end
                end
                PH_SCREEN: begin
                    if (fcnt < 4'd4) begin
                        if (fcnt[0]) wd[fcnt[2:1]][15:8] = b;
                        else wd[fcnt[2:1]] = {8'h00, b};
                        fcnt = fcnt + 4'd1;
                    end else if (fcnt == 4'd4) begin
                        sv_flags = b;
                        fcnt = 4'd5;
                        got = 1'b1;
                        rec.kind = KIND_HEADER;
                        rec.word_a = wd[0];
                        rec.word_b = wd[1];
                        rec.word_c = wd[2];
                        rec.flag_byte = b;
                        rec.color_bits = {1'b0, b[2:0]} + 4'd1;
                    end else if (fcnt == 4'd5) begin
                        fcnt = 4'd6;
                    end else begin
                        fcnt = '0;
                        if (sv_flags[7]) begin
                            skip_left = color_table_len(sv_flags);
                            ph = PH_GTAB;
                        end else begin
                            ph = PH_TAG;
                        end
                    end
                end
                PH_GTAB, PH_LTAB: begin
                    if (skip_left != '0) skip_left = skip_left - 10'd1;
                    if (skip_left == '0) ph = (ph == PH_GTAB) ? PH_TAG : PH_LZW;
                end
                PH_TAG: begin
                    case (b)
                        TAG_EXTENSION: ph = PH_EXTLAB;
                        TAG_IMAGE: begin
                            ph = PH_IMG;
                            fcnt = '0;
                        end
                        TAG_TRAILER: begin
                            stopped = 1'b1;
                            got = 1'b1;
                            rec.kind = KIND_TRAILER;
                        end
                        TAG_2E: begin
                            stopped = 1'b1;
                            got = 1'b1;
                            rec.kind = KIND_TAG_2E;
                        end
                        default: begin
                            wd[0] = {8'h00, b};
                            ph = PH_UNK;
                        end
                    endcase
                end
                PH_UNK: begin
                    stopped = 1'b1;
                    got = 1'b1;
                    rec.kind = KIND_UNKNOWN_TAG;
                    rec.word_a = {8'h00, wd[0][7:0]};
                    rec.word_b = {8'h00, b};
                end
                PH_EXTLAB: begin
                    case (b)
                        LBL_PLAIN: begin
                            ph = PH_SKIPLEN;
                            got = 1'b1;
                            rec.kind = KIND_PLAIN_TEXT;
                        end
                        LBL_APP: begin
                            ph = PH_SKIPLEN;
                            got = 1'b1;
                            rec.kind = KIND_APPLICATION;
                        end
                        LBL_COMMENT: ph = PH_COMLEN;
                        LBL_GFX: begin
                            ph = PH_GCELEN;
                            fcnt = '0;
                            sv_flags = '0;
                            sv_index = '0;
                            wd[0] = '0;
                        end
                        default: ph = PH_SKIPLEN;
                    endcase
                end
                PH_SKIPLEN, PH_COMLEN, PH_GCELEN: begin
                    if (b == 8'h00) begin
                        if (ph == PH_COMLEN) begin
                            got = 1'b1;
                            rec.kind = KIND_COMMENT_END;
                        end else if (ph == PH_GCELEN) begin
                            got = 1'b1;
                            rec.kind = KIND_GFX_CONTROL;
                            rec.word_a = wd[0];
                            rec.flag_byte = sv_flags;
                            rec.color_index = sv_index;
                            rec.has_transparency = sv_flags[0];
                        end
                        ph = PH_TAG;
                    end else begin
                        skip_left = {2'b00, b};
                        // only the first control sub-block carries fields
                        if (ph == PH_GCELEN) fcnt = (fcnt == '0) ? 4'd1 : 4'd15;
                        ph = (ph == PH_SKIPLEN) ? PH_SKIPDAT :
                             (ph == PH_COMLEN)  ? PH_COMDAT  : PH_GCEDAT;
                    end
                end
                PH_SKIPDAT, PH_COMDAT, PH_GCEDAT: begin
                    was = ph;
                    if (skip_left != '0) skip_left = skip_left - 10'd1;
                    if (skip_left == '0) begin
                        ph = (was == PH_SKIPDAT) ? PH_SKIPLEN :
                             (was == PH_COMDAT)  ? PH_COMLEN  : PH_GCELEN;
                    end
                    if (was == PH_COMDAT) begin
                        got = 1'b1;
                        rec.kind = KIND_COMMENT;
                        rec.text_byte = b;
                    end else if (was == PH_GCEDAT && fcnt >= 4'd1 && fcnt <= 4'd4) begin
                        case (fcnt)
                            4'd1:    sv_flags = b;
                            4'd2:    wd[0] = {8'h00, b};
                            4'd3:    wd[0][15:8] = b;
                            default: sv_index = b;
                        endcase
                        fcnt = fcnt + 4'd1;
                    end
                end
                PH_IMG: begin
                    if (fcnt < 4'd8) begin
                        if (fcnt[0]) wd[fcnt[2:1]][15:8] = b;
                        else wd[fcnt[2:1]] = {8'h00, b};
                        fcnt = fcnt + 4'd1;
                    end else begin
                        sv_flags = b;
                        fcnt = '0;
                        if (b[7]) begin
                            skip_left = color_table_len(b);
                            ph = PH_LTAB;
                        end else begin
                            ph = PH_LZW;
                        end
                        got = 1'b1;
                        rec.kind = KIND_IMAGE;
                        rec.word_a = wd[0];
                        rec.word_b = wd[1];
                        rec.word_c = wd[2];
                        rec.word_d = wd[3];
                        rec.flag_byte = b;
                        rec.color_bits = {1'b0, b[2:0]} + 4'd1;
                        rec.local_table = b[7];
                        rec.interlaced = b[6];
                    end
                end
                // drop the LZW minimum code size byte
                PH_LZW: ph = PH_SKIPLEN;
                default: ph = PH_TAG;
            endcase
        end
    endtask

    task automatic match_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_record want;
        t_record made;
        logic    got;
        if (!i_rst_n) begin
            reset_walker();
            pending_records.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_records.size() == 0) begin
                    $error("record_kind: expected no record, got %0h", i_record_kind);
                    errors++;
                end else begin
                    want = pending_records.pop_front();
                    match_field("record_kind", 16'(want.kind), 16'(i_record_kind));
                    match_field("word_a", want.word_a, i_word_a);
                    match_field("word_b", want.word_b, i_word_b);
                    match_field("word_c", want.word_c, i_word_c);
                    match_field("word_d", want.word_d, i_word_d);
                    match_field("flag_byte", 16'(want.flag_byte), 16'(i_flag_byte));
                    match_field("color_bits", 16'(want.color_bits), 16'(i_color_bits));
                    match_field("color_index", 16'(want.color_index), 16'(i_color_index));
                    match_field("has_transparency", 16'(want.has_transparency),
                                16'(i_has_transparency));
                    match_field("local_table", 16'(want.local_table), 16'(i_local_table));
                    match_field("interlaced", 16'(want.interlaced), 16'(i_interlaced));
                    match_field("text_byte", 16'(want.text_byte), 16'(i_text_byte));
                    records_seen++;
                    kinds[want.kind] = 1'b1;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                walk_gif_byte(i_data_byte, i_first_byte, got, made);
                if (got) pending_records.push_back(made);
            end
        end
        o_fail_count <= errors;
        o_pending    <= pending_records.size();
        o_records    <= records_seen;
        o_kinds_seen <= kinds;
    end

endmodule

/* tb/tb_gif_block_structure_parser.sv */
// Top of the GIF block structure parser testbench: builds a byte stream of
// directed and random GIF files, feeds it in bursts and stalls the record side.
// Depends on gbsp_pkg, gif_block_structure_parser and gif_record_checker.
module tb_gif_block_structure_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import gbsp_pkg::*;

    localparam int          RANDOM_BYTES = 800;
    localparam logic [31:0] GIF_MAGIC    = 32'h3846_4947;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [7:0]  data_byte  = 8'h00;
    logic        first_byte = 1'b0;
    logic        out_stall  = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [3:0]  record_kind;
    logic [15:0] word_a, word_b, word_c, word_d;
    logic [7:0]  flag_byte;
    logic [3:0]  color_bits;
    logic [7:0]  color_index;
    logic        has_transparency, local_table, interlaced;
    logic [7:0]  text_byte;

    int          fail_count, pending_n, records_n;
    logic [15:0] kinds_seen;

    logic [8:0]  gif_stream [$];
    int          directed_len = 0;
    int          files_made   = 0;
    int          bytes_sent   = 0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    gif_block_structure_parser dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_data_byte        (data_byte),
        .i_first_byte       (first_byte),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_record_kind      (record_kind),
        .o_word_a           (word_a),
        .o_word_b           (word_b),
        .o_word_c           (word_c),
        .o_word_d           (word_d),
        .o_flag_byte        (flag_byte),
        .o_color_bits       (color_bits),
        .o_color_index      (color_index),
        .o_has_transparency (has_transparency),
        .o_local_table      (local_table),
        .o_interlaced       (interlaced),
        .o_text_byte        (text_byte)
    );

    gif_record_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_data_byte        (data_byte),
        .i_first_byte       (first_byte),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_record_kind      (record_kind),
        .i_word_a           (word_a),
        .i_word_b           (word_b),
        .i_word_c           (word_c),
        .i_word_d           (word_d),
        .i_flag_byte        (flag_byte),
        .i_color_bits       (color_bits),
        .i_color_index      (color_index),
        .i_has_transparency (has_transparency),
        .i_local_table      (local_table),
        .i_interlaced       (interlaced),
        .i_text_byte        (text_byte),
        .o_fail_count       (fail_count),
        .o_pending          (pending_n),
        .o_records          (records_n),
        .o_kinds_seen       (kinds_seen)
    );

    task automatic put_byte(input logic first, input logic [7:0] b);
        gif_stream.push_back({first, b});
    endtask

    task automatic put_word(input logic [15:0] w);
        put_byte(1'b0, w[7:0]);
        put_byte(1'b0, w[15:8]);
    endtask

    task automatic put_random_bytes(input int n);
        for (int i = 0; i < n; i++) put_byte(1'b0, 8'($urandom));
    endtask

    function automatic logic [15:0] rand_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'hffff;
        return 16'($urandom);
    endfunction

    // Keep color tables short apart from a rare one of random size.
    function automatic logic [7:0] rand_table_flags();
        logic [7:0] f;
        f = 8'($urandom);
        if (f[7] && $urandom_range(0, 39) != 0) f[2:0] = 3'($urandom_range(0, 1));
        return f;
    endfunction

    task automatic put_header(input logic [7:0] ver_lo, input logic [7:0] ver_hi,
                              input logic [15:0] width, input logic [15:0] height,
                              input logic [7:0] flags);
        for (int i = 0; i < 4; i++) put_byte(i == 0, GIF_MAGIC[i*8 +: 8]);
        put_byte(1'b0, ver_lo);
        put_byte(1'b0, ver_hi);
        put_word(width);
        put_word(height);
        put_byte(1'b0, flags);
        put_random_bytes(2);
        if (flags[7]) put_random_bytes(3 << (flags[2:0] + 1));
    endtask

    // Sub-block chain closed by a zero length byte.
    task automatic put_sub_blocks(input int max_len);
        int nblk, len;
        nblk = $urandom_range(0, 3);
        for (int i = 0; i < nblk; i++) begin
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(1, 255)
                                               : $urandom_range(1, max_len);
            put_byte(1'b0, 8'(len));
            put_random_bytes(len);
        end
        put_byte(1'b0, 8'h00);
    endtask

    task automatic put_directed();
        // no restart marker straight after reset: rejected at signature byte 0
        put_byte(1'b0, 8'h00);
        put_header(8'h39, 8'h61, 16'hffff, 16'h0000, 8'h07);
        put_byte(1'b0, TAG_EXTENSION);
        put_byte(1'b0, LBL_GFX);
        put_byte(1'b0, 8'h04);
        put_byte(1'b0, 8'h01);
        put_word(16'h1234);
        put_byte(1'b0, 8'hff);
        put_byte(1'b0, 8'h00);
        put_byte(1'b0, TAG_EXTENSION);
        put_byte(1'b0, LBL_COMMENT);
        put_byte(1'b0, 8'h01);
        put_byte(1'b0, 8'h7e);
        put_byte(1'b0, 8'h00);
        put_byte(1'b0, TAG_EXTENSION);
        put_byte(1'b0, LBL_PLAIN);
        put_byte(1'b0, 8'h00);
        put_byte(1'b0, TAG_EXTENSION);
        put_byte(1'b0, LBL_APP);
        put_byte(1'b0, 8'h00);
        put_byte(1'b0, TAG_IMAGE);
        put_word(16'h0000);
        put_word(16'hffff);
        put_word(16'h0001);
        put_word(16'hffff);
        put_byte(1'b0, 8'h40);
        put_byte(1'b0, 8'h02);
        put_byte(1'b0, 8'h00);
        put_byte(1'b0, TAG_2E);
    endtask

    task automatic put_random_file();
        int n, r, k;
        logic [7:0] f, b;
        files_made++;
        r = $urandom_range(0, 11);
        if (r == 0) begin
            // corrupt one signature byte
            k = $urandom_range(0, 3);
            for (int i = 0; i < k; i++) put_byte(i == 0, GIF_MAGIC[i*8 +: 8]);
            put_byte(k == 0, GIF_MAGIC[k*8 +: 8] ^ 8'($urandom_range(1, 255)));
            put_random_bytes($urandom_range(0, 3));
            return;
        end
        if ($urandom_range(0, 3) == 0) put_header(8'($urandom), 8'($urandom),
                                                  rand_word(), rand_word(), rand_table_flags());
        else put_header(($urandom_range(0, 1) != 0) ? 8'h39 : 8'h37, 8'h61,
                        rand_word(), rand_word(), rand_table_flags());
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 6))
                0: begin
                    put_byte(1'b0, TAG_EXTENSION);
                    put_byte(1'b0, LBL_GFX);
                    r = $urandom_range(0, 5);
                    if (r <= 3) begin
                        put_byte(1'b0, 8'h04);
                        put_random_bytes(4);
                        if (r == 3) put_sub_blocks(8);
                        else put_byte(1'b0, 8'h00);
                    end else if (r == 4) begin
                        put_sub_blocks(8);
                    end else begin
                        put_byte(1'b0, 8'h00);
                    end
                end
                1: begin
                    put_byte(1'b0, TAG_EXTENSION);
                    put_byte(1'b0, LBL_COMMENT);
                    put_sub_blocks(12);
                end
                2: begin
                    put_byte(1'b0, TAG_EXTENSION);
                    put_byte(1'b0, LBL_PLAIN);
                    put_sub_blocks(16);
                end
                3: begin
                    put_byte(1'b0, TAG_EXTENSION);
                    put_byte(1'b0, LBL_APP);
                    put_sub_blocks(16);
                end
                4: begin
                    do b = 8'($urandom);
                    while (b == LBL_PLAIN || b == LBL_GFX || b == LBL_COMMENT || b == LBL_APP);
                    put_byte(1'b0, TAG_EXTENSION);
                    put_byte(1'b0, b);
                    put_sub_blocks(16);
                end
                default: begin
                    put_byte(1'b0, TAG_IMAGE);
                    for (int j = 0; j < 4; j++) put_word(rand_word());
                    f = rand_table_flags();
                    put_byte(1'b0, f);
                    if (f[7]) put_random_bytes(3 << (f[2:0] + 1));
                    put_byte(1'b0, 8'($urandom));
                    put_sub_blocks(20);
                end
            endcase
        end
        r = $urandom_range(0, 9);
        if (r <= 5) begin
            put_byte(1'b0, TAG_TRAILER);
        end else if (r == 6) begin
            put_byte(1'b0, TAG_2E);
        end else if (r == 7) begin
            do b = 8'($urandom);
            while (b == TAG_EXTENSION || b == TAG_IMAGE || b == TAG_TRAILER || b == TAG_2E);
            put_byte(1'b0, b);
            put_byte(1'b0, 8'($urandom));
        end
        // truncated files end here or run on into random bytes; halted ones may trail ignored bytes
        if (r != 8 && $urandom_range(0, 2) == 0) put_random_bytes($urandom_range(1, 4));
    endtask

    initial begin : feed
        int burst, gap, k, r;
        put_directed();
        directed_len = gif_stream.size();
        while (gif_stream.size() < directed_len + RANDOM_BYTES) put_random_file();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        k = 0;
        while (k < gif_stream.size()) begin
            burst = $urandom_range(1, 64);
            while (burst > 0 && k < gif_stream.size()) begin
                in_valid   <= 1'b1;
                first_byte <= gif_stream[k][8];
                data_byte  <= gif_stream[k][7:0];
                @(posedge clk);
                while (in_stall) @(posedge clk);
                k++;
                bytes_sent++;
                burst--;
            end
            r = $urandom_range(0, 9);
            gap = (r < 4) ? 0 : (r < 8) ? $urandom_range(1, 4) : $urandom_range(8, 30);
            if (gap > 0 && k < gif_stream.size()) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_n != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        $display("Fed %0d bytes: %0d directed, then %0d random files; %0d records compared.",
                 bytes_sent, directed_len, files_made, records_n);
        $display("Record kinds seen, one bit per kind code: %b", kinds_seen[10:0]);
        if (fail_count == 0) begin
            $display("[gif_block_structure_parser] OK");
        end else begin
            $display("[gif_block_structure_parser] ERROR");
        end
        $finish;
    end

    initial begin : drain
        int mode, seg, k, next_hold;
        next_hold = 150;
        @(posedge clk);
        forever begin
            // hold off long enough for the parser to back up into its input
            if (bytes_sent >= next_hold) begin
                next_hold += 450;
                out_stall <= 1'b1;
                for (k = 0; k < 300; k++) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            seg = $urandom_range(10, 120);
            for (k = 0; k < seg; k++) begin
                case (mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 3) == 0);
                    2:       out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= k[2];
                endcase
                @(posedge clk);
            end
        end
    end

    initial begin : watchdog
        #10_000_000;
        $display("[gif_block_structure_parser] ERROR");
        $finish;
    end

endmodule
